### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

### hw/rtl/htd_pkg.sv
// Package: constants, op codes and sequencer states of the Huffman tree decoder.
package htd_pkg;

  localparam int ALPHABET_DEF  = 256;
  localparam int FREQ_BITS_DEF = 32;
  localparam int TOTAL_BITS    = 40;
  localparam int BYTE_BITS     = 8;
  localparam int FREQ_IN_BITS  = 32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_DECODE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAF,
    ST_SCAN,
    ST_TAKE,
    ST_MERGE,
    ST_DEC,
    ST_END
  } state_t;

endpackage

### hw/rtl/htd_freq_mem.sv
// Frequency store: one-write, one-read memory with per-entry valid bits cleared at reset.
module htd_freq_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DW-1:0]    rmem;
  logic             rvalid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rmem <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rvalid <= valid[raddr];
    end
  end

  assign rdata = rvalid ? rmem : '0;

endmodule

### hw/rtl/htd_node_mem.sv
// Node store: tree node records, one write and one registered read per cycle.
module htd_node_mem #(
  parameter int DEPTH = 511,
  parameter int AW    = 9,
  parameter int DW    = 68
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/huffman_tree_decoder.sv
// Top level: Huffman decoder that builds its code tree from loaded symbol frequencies.
//
//   channel   direction  handshake              fields
//   in        input      in_valid / in_ready    op, symbol_index, frequency, code_byte
//   out       output     out_valid / out_ready  symbol, last, finished
//   cfg       input      cfg_wr_en              cfg_wr_data (total_symbols)
//
// Load: a frequency write, taken in idle. Decode: each byte is accepted, walked in up to
// eight bit steps with one node-store read per bit (none for a one-leaf tree), flushed;
// a byte with nothing to decode is dropped. Build: a leaf pass over all symbols, then
// (n-1) merges, each two node-store min scans, two takes, a write (n = nonzero freqs).
// Reset clears the frequency valid bits at once; no clearing pass.
// A stalled out channel holds the decode at the next leaf; in_ready is high in idle only.
module huffman_tree_decoder
  import htd_pkg::*;
#(
  parameter int ALPHABET  = ALPHABET_DEF,
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [7:0]            symbol_index,
  input  logic [31:0]           frequency,
  input  logic [7:0]            code_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            symbol,
  output logic                  last,
  output logic                  finished,
  input  logic                  cfg_wr_en,
  input  logic [TOTAL_BITS-1:0] cfg_wr_data
);

  `include "assert_macros.svh"

  localparam int NODES = 2 * ALPHABET - 1;
  localparam int NB    = $clog2(NODES);
  localparam int AB    = $clog2(ALPHABET);
  localparam int WB    = FREQ_BITS + AB;
  localparam int FW    = (FREQ_BITS > FREQ_IN_BITS) ? FREQ_BITS : FREQ_IN_BITS;

  typedef struct packed {
    logic [WB-1:0] weight;
    logic [7:0]    tag;
    logic [NB-1:0] left;
    logic [NB-1:0] right;
    logic          leaf;
    logic          active;
  } node_t;

  state_t state, state_next;

  logic [TOTAL_BITS-1:0] total, cnt, cnt_next, cnt_inc;
  logic                  tree_ready, tree_ready_next;
  logic                  single, single_next;
  logic [NB-1:0]         used, used_next;
  logic [AB:0]           fidx, fidx_next;
  logic                  lrd_v, lrd_v_next;
  logic [AB-1:0]         lsym, lsym_next;
  node_t                 leaf_rec, leaf_rec_next;
  logic [NB-1:0]         merges_left, merges_left_next;
  logic [NB-1:0]         sj, sj_next;
  logic                  s_iss, s_iss_next;
  logic                  s_rv, s_rv_next;
  logic [NB-1:0]         s_ridx, s_ridx_next;
  logic                  best_f, best_f_next;
  node_t                 best_rec, best_rec_next;
  logic [NB-1:0]         best_idx, best_idx_next;
  logic                  pick, pick_next;
  node_t                 a_rec, a_rec_next;
  logic [NB-1:0]         a_idx, a_idx_next;
  node_t                 root_rec, root_rec_next;
  node_t                 walk_rec, walk_rec_next;
  node_t                 nxt_rec, merge_rec;
  logic [7:0]            bits, bits_next;
  logic [3:0]            bcnt, bcnt_next;
  logic                  held_v, held_v_next;
  logic [7:0]            held_sym, held_sym_next;
  logic                  held_fin, held_fin_next;
  logic                  out_v, out_v_next;
  logic [7:0]            out_sym, out_sym_next;
  logic                  out_last, out_last_next;
  logic                  out_fin, out_fin_next;
  logic                  out_full, leaf_ev, ev_fin, sym_ok;
  logic [7:0]            ev_sym;

  logic                  f_we;
  logic [AB-1:0]         f_raddr;
  logic [FREQ_BITS-1:0]  f_wdata, f_rdata;
  logic [FW-1:0]         f_ext;

  logic                  n_we, n_re;
  logic [NB-1:0]         n_waddr, n_raddr;
  node_t                 n_wdata, n_rdata;

  assign f_ext   = FW'(frequency);
  assign f_wdata = f_ext[FREQ_BITS-1:0];
  assign sym_ok  = {1'b0, symbol_index} < 9'(ALPHABET);

  htd_freq_mem #(.DEPTH(ALPHABET), .AW(AB), .DW(FREQ_BITS)) u_freq (
    .clk   (clk),
    .rst   (rst),
    .we    (f_we),
    .waddr (symbol_index[AB-1:0]),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  htd_node_mem #(.DEPTH(NODES), .AW(NB), .DW($bits(node_t))) u_node (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .re    (n_re),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_v;
  assign symbol    = out_sym;
  assign last      = out_last;
  assign finished  = out_fin;
  assign out_full  = out_v && !out_ready;
  assign cnt_inc   = cnt + 1'b1;
  assign leaf_ev   = single || n_rdata.leaf;
  assign ev_sym    = single ? root_rec.tag : n_rdata.tag;
  assign ev_fin    = (cnt_inc >= total);

  always_comb begin
    merge_rec        = '0;
    merge_rec.weight = a_rec.weight + best_rec.weight;
    merge_rec.left   = a_idx;
    merge_rec.right  = best_idx;
    merge_rec.active = 1'b1;
  end

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    tree_ready_next  = tree_ready;
    single_next      = single;
    used_next        = used;
    fidx_next        = fidx;
    lrd_v_next       = lrd_v;
    lsym_next        = lsym;
    leaf_rec_next    = leaf_rec;
    merges_left_next = merges_left;
    sj_next          = sj;
    s_iss_next       = s_iss;
    s_rv_next        = s_rv;
    s_ridx_next      = s_ridx;
    best_f_next      = best_f;
    best_rec_next    = best_rec;
    best_idx_next    = best_idx;
    pick_next        = pick;
    a_rec_next       = a_rec;
    a_idx_next       = a_idx;
    root_rec_next    = root_rec;
    walk_rec_next    = walk_rec;
    nxt_rec          = root_rec;
    bits_next        = bits;
    bcnt_next        = bcnt;
    held_v_next      = held_v;
    held_sym_next    = held_sym;
    held_fin_next    = held_fin;
    out_v_next       = (out_v && out_ready) ? 1'b0 : out_v;
    out_sym_next     = out_sym;
    out_last_next    = out_last;
    out_fin_next     = out_fin;
    f_we             = 1'b0;
    f_raddr          = fidx[AB-1:0];
    n_we             = 1'b0;
    n_waddr          = used;
    n_wdata          = '0;
    n_re             = 1'b0;
    n_raddr          = sj;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority case (op)
            OP_LOAD: begin
              f_we = sym_ok;
            end
            OP_BUILD: begin
              state_next      = ST_LEAF;
              fidx_next       = '0;
              lrd_v_next      = 1'b0;
              used_next       = '0;
              tree_ready_next = 1'b0;
              single_next     = 1'b0;
              cnt_next        = '0;
            end
            OP_DECODE: begin
              if (tree_ready && (cnt < total)) begin
                bits_next  = code_byte;
                bcnt_next  = 4'(BYTE_BITS);
                state_next = ST_DEC;
                if (!single) begin
                  n_re    = 1'b1;
                  n_raddr = code_byte[7] ? walk_rec.right : walk_rec.left;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_LEAF: begin
        if (fidx < (AB + 1)'(ALPHABET)) begin
          fidx_next  = fidx + 1'b1;
          lrd_v_next = 1'b1;
          lsym_next  = fidx[AB-1:0];
        end else begin
          lrd_v_next = 1'b0;
        end
        if (lrd_v && (f_rdata != '0)) begin
          n_we                 = 1'b1;
          n_waddr              = used;
          n_wdata              = '0;
          n_wdata.weight       = WB'(f_rdata);
          n_wdata.tag          = 8'(lsym);
          n_wdata.leaf         = 1'b1;
          n_wdata.active       = 1'b1;
          leaf_rec_next        = n_wdata;
          used_next            = used + 1'b1;
        end
        if ((fidx == (AB + 1)'(ALPHABET)) && !lrd_v) begin
          if (used == '0) begin
            state_next = ST_IDLE;
          end else if (used == NB'(1)) begin
            tree_ready_next = 1'b1;
            single_next     = 1'b1;
            root_rec_next   = leaf_rec;
            walk_rec_next   = leaf_rec;
            state_next      = ST_IDLE;
          end else begin
            tree_ready_next  = 1'b1;
            merges_left_next = used - 1'b1;
            pick_next        = 1'b0;
            sj_next          = used - 1'b1;
            s_iss_next       = 1'b1;
            s_rv_next        = 1'b0;
            best_f_next      = 1'b0;
            state_next       = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (s_iss) begin
          n_re        = 1'b1;
          n_raddr     = sj;
          s_rv_next   = 1'b1;
          s_ridx_next = sj;
          if (sj == '0) begin
            s_iss_next = 1'b0;
          end else begin
            sj_next = sj - 1'b1;
          end
        end else begin
          s_rv_next = 1'b0;
        end
        if (s_rv && n_rdata.active &&
            (!best_f || (n_rdata.weight < best_rec.weight) ||
             ((n_rdata.weight == best_rec.weight) && (n_rdata.tag < best_rec.tag)))) begin
          best_f_next   = 1'b1;
          best_rec_next = n_rdata;
          best_idx_next = s_ridx;
        end
        if (!s_iss && !s_rv) begin
          state_next = ST_TAKE;
        end
      end

      ST_TAKE: begin
        n_we           = 1'b1;
        n_waddr        = best_idx;
        n_wdata        = best_rec;
        n_wdata.active = 1'b0;
        if (!pick) begin
          a_rec_next  = best_rec;
          a_idx_next  = best_idx;
          pick_next   = 1'b1;
          sj_next     = used - 1'b1;
          s_iss_next  = 1'b1;
          s_rv_next   = 1'b0;
          best_f_next = 1'b0;
          state_next  = ST_SCAN;
        end else begin
          state_next = ST_MERGE;
        end
      end

      ST_MERGE: begin
        n_we             = 1'b1;
        n_waddr          = used;
        n_wdata          = merge_rec;
        used_next        = used + 1'b1;
        merges_left_next = merges_left - 1'b1;
        if (merges_left == NB'(1)) begin
          root_rec_next = merge_rec;
          walk_rec_next = merge_rec;
          state_next    = ST_IDLE;
        end else begin
          pick_next   = 1'b0;
          sj_next     = used;
          s_iss_next  = 1'b1;
          s_rv_next   = 1'b0;
          best_f_next = 1'b0;
          state_next  = ST_SCAN;
        end
      end

      ST_DEC: begin
        if (!(leaf_ev && held_v && out_full)) begin
          if (leaf_ev) begin
            if (held_v) begin
              out_v_next    = 1'b1;
              out_sym_next  = held_sym;
              out_last_next = 1'b0;
              out_fin_next  = held_fin;
            end
            held_v_next   = 1'b1;
            held_sym_next = ev_sym;
            held_fin_next = ev_fin;
            cnt_next      = cnt_inc;
            walk_rec_next = root_rec;
            nxt_rec       = root_rec;
          end else begin
            walk_rec_next = n_rdata;
            nxt_rec       = n_rdata;
          end
          bits_next = {bits[6:0], 1'b0};
          bcnt_next = bcnt - 1'b1;
          if ((bcnt == 4'd1) || (leaf_ev && ev_fin)) begin
            state_next = ST_END;
          end else if (!single) begin
            n_re    = 1'b1;
            n_raddr = bits[6] ? nxt_rec.right : nxt_rec.left;
          end
        end
      end

      ST_END: begin
        if (!held_v) begin
          state_next = ST_IDLE;
        end else if (!out_full) begin
          out_v_next    = 1'b1;
          out_sym_next  = held_sym;
          out_last_next = 1'b1;
          out_fin_next  = held_fin;
          held_v_next   = 1'b0;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      total      <= '0;
      cnt        <= '0;
      tree_ready <= 1'b0;
      single     <= 1'b0;
      used       <= '0;
      fidx       <= '0;
      lrd_v      <= 1'b0;
      s_iss      <= 1'b0;
      s_rv       <= 1'b0;
      best_f     <= 1'b0;
      pick       <= 1'b0;
      held_v     <= 1'b0;
      out_v      <= 1'b0;
      merges_left <= '0;
      bcnt       <= '0;
    end else begin
      state      <= state_next;
      if (cfg_wr_en) begin
        total <= cfg_wr_data;
      end
      cnt        <= cnt_next;
      tree_ready <= tree_ready_next;
      single     <= single_next;
      used       <= used_next;
      fidx       <= fidx_next;
      lrd_v      <= lrd_v_next;
      s_iss      <= s_iss_next;
      s_rv       <= s_rv_next;
      best_f     <= best_f_next;
      pick       <= pick_next;
      held_v     <= held_v_next;
      out_v      <= out_v_next;
      merges_left <= merges_left_next;
      bcnt       <= bcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    lsym     <= lsym_next;
    leaf_rec <= leaf_rec_next;
    sj       <= sj_next;
    s_ridx   <= s_ridx_next;
    best_rec <= best_rec_next;
    best_idx <= best_idx_next;
    a_rec    <= a_rec_next;
    a_idx    <= a_idx_next;
    root_rec <= root_rec_next;
    walk_rec <= walk_rec_next;
    bits     <= bits_next;
    held_sym <= held_sym_next;
    held_fin <= held_fin_next;
    out_sym  <= out_sym_next;
    out_last <= out_last_next;
    out_fin  <= out_fin_next;
  end

  `ASSERT_IMPLIES(a_idle_no_held, clk, rst, in_ready, !held_v, "held item left at idle")
  `ASSERT_IMPLIES(a_dec_tree, clk, rst, state == ST_DEC, tree_ready, "decode without tree")
  `ASSERT_IMPLIES(a_merge_distinct, clk, rst, state == ST_MERGE, a_idx != best_idx, "self merge")
  `ASSERT_NEXT(a_take_merge, clk, rst, (state == ST_TAKE) && pick, state == ST_MERGE, "no merge")

endmodule
